>>> src/fmrb_pkg.sv
// Shared types and constants for the framed message ring buffer.
package fmrb_pkg;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [2:0] FUNC_OPEN     = 3'd0;
    localparam logic [2:0] FUNC_APPEND   = 3'd1;
    localparam logic [2:0] FUNC_CLOSE    = 3'd2;
    localparam logic [2:0] FUNC_RD_START = 3'd3;
    localparam logic [2:0] FUNC_RD_BYTE  = 3'd4;
    localparam logic [2:0] FUNC_RD_COMMIT = 3'd5;

    localparam int unsigned OPEN_MIN_FREE = 34;
    localparam logic [5:0]  MAX_DATA      = 6'd31;
    localparam logic [5:0]  LEN_OVERHEAD  = 6'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLOSE2,
        ST_RD_START,
        ST_RD_BYTE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic close2;
        logic rd_start_done;
        logic rd_byte_done;
        logic finish;
        logic load_now;
        logic load_held;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       msg_open;
        logic       rd_empty;
        logic       drain_zero;
        logic       out_free;
    } t_status;

endpackage

>>> src/fmrb_ctrl.sv
// Controller state machine that sequences each word through the datapath.
module fmrb_ctrl
    import fmrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic done;
        done       = 1'b0;
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.func == FUNC_CLOSE && i_status.msg_open) begin
                    n_state = ST_CLOSE2;
                end else if (i_status.func == FUNC_RD_START && !i_status.rd_empty) begin
                    n_state = ST_RD_START;
                end else if (i_status.func == FUNC_RD_BYTE && !i_status.drain_zero) begin
                    n_state = ST_RD_BYTE;
                end else begin
                    done = 1'b1;
                end
            end
            ST_CLOSE2: begin
                o_cmd.close2 = 1'b1;
                done         = 1'b1;
            end
            ST_RD_START: begin
                o_cmd.rd_start_done = 1'b1;
                done                = 1'b1;
            end
            ST_RD_BYTE: begin
                o_cmd.rd_byte_done = 1'b1;
                done               = 1'b1;
            end
            ST_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load_held = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (done) begin
            o_cmd.finish   = 1'b1;
            o_cmd.load_now = i_status.out_free;
            n_state        = i_status.out_free ? ST_IDLE : ST_HOLD;
        end
    end

endmodule

>>> src/fmrb_dp.sv
// Datapath with the byte store, ring pointers, checksum and result register.
module fmrb_dp
    import fmrb_pkg::*;
#(
    parameter int STORE_DEPTH = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [IN_TUSER_W-1:0]  i_in_user,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(STORE_DEPTH - 1);
    localparam logic [AW:0]   MIN_FREE = (AW + 1)'(OPEN_MIN_FREE);

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW:0] ring_diff(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] ea;
        logic [AW:0] eb;
        ea = {1'b0, a};
        eb = {1'b0, b};
        return (a >= b) ? (ea - eb) : (ea + DEPTH_W - eb);
    endfunction

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    logic [2:0]    r_func;
    logic [7:0]    r_data;
    logic          r_is_char;
    logic [AW-1:0] r_cwp;
    logic [AW-1:0] r_fill_pos;
    logic [5:0]    r_fill_count;
    logic [7:0]    r_sum;
    logic          r_open;
    logic [AW-1:0] r_crp;
    logic [AW-1:0] r_drain_pos;
    logic [5:0]    r_drain_left;
    logic [OUT_TDATA_W-1:0] r_res;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_valid;

    logic          w_free_ok;
    logic          w_rd_empty;
    logic          w_app_refused;
    logic [7:0]    w_len_byte;
    logic [5:0]    w_drain_dec;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_open_ok;
    logic          w_ignored;
    logic [5:0]    w_mlen;
    logic [7:0]    w_rbyte;
    logic [OUT_TDATA_W-1:0] w_res;

    assign w_free_ok     = ring_diff(r_crp, r_cwp) >= MIN_FREE;
    assign w_rd_empty    = ring_diff(r_cwp, r_crp) == (AW + 1)'(1);
    assign w_app_refused = !r_open || (r_fill_count >= MAX_DATA);
    assign w_len_byte    = {r_is_char, 1'b0, r_fill_count};
    assign w_drain_dec   = r_drain_left - 6'd1;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_fill_pos;
        w_wr_data = r_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_drain_pos;
        if (i_cmd.exec) begin
            case (r_func)
                FUNC_APPEND: begin
                    w_wr_en = !w_app_refused;
                end
                FUNC_CLOSE: begin
                    w_wr_en   = r_open;
                    w_wr_addr = r_cwp;
                    w_wr_data = w_len_byte;
                end
                FUNC_RD_START: begin
                    w_rd_en   = !w_rd_empty;
                    w_rd_addr = next_pos(r_crp);
                end
                FUNC_RD_BYTE: begin
                    w_rd_en = (r_drain_left != 6'd0);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.close2) begin
            w_wr_en   = 1'b1;
            w_wr_data = 8'd0 - r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_in_user;
            r_data    <= i_in_data[7:0];
            r_is_char <= i_in_data[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwp        <= AW'(1);
            r_fill_pos   <= '0;
            r_fill_count <= '0;
            r_sum        <= '0;
            r_open       <= 1'b0;
            r_crp        <= '0;
            r_drain_pos  <= '0;
            r_drain_left <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_func)
                    FUNC_OPEN: begin
                        if (w_free_ok) begin
                            r_fill_pos   <= next_pos(r_cwp);
                            r_fill_count <= '0;
                            r_sum        <= '0;
                            r_open       <= 1'b1;
                        end
                    end
                    FUNC_APPEND: begin
                        if (!w_app_refused) begin
                            r_fill_pos   <= next_pos(r_fill_pos);
                            r_fill_count <= r_fill_count + 6'd1;
                            r_sum        <= r_sum + r_data;
                        end
                    end
                    FUNC_CLOSE: begin
                        if (r_open) begin
                            r_sum <= r_sum + w_len_byte;
                        end
                    end
                    FUNC_RD_START: begin
                        if (!w_rd_empty) begin
                            r_drain_pos <= next_pos(r_crp);
                        end
                    end
                    FUNC_RD_COMMIT: begin
                        r_crp <= r_drain_pos;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.close2) begin
                r_cwp  <= next_pos(r_fill_pos);
                r_open <= 1'b0;
            end
            if (i_cmd.rd_start_done) begin
                r_drain_left <= {1'b0, r_rdata[4:0]} + LEN_OVERHEAD;
            end
            if (i_cmd.rd_byte_done) begin
                r_drain_left <= w_drain_dec;
                if (w_drain_dec != 6'd0) begin
                    r_drain_pos <= next_pos(r_drain_pos);
                end
            end
        end
    end

    always_comb begin
        w_open_ok = i_cmd.exec && (r_func == FUNC_OPEN) && w_free_ok;
        w_ignored = i_cmd.exec && (((r_func == FUNC_APPEND) && w_app_refused)
                    || ((r_func == FUNC_CLOSE) && !r_open));
        w_mlen    = i_cmd.rd_start_done ? ({1'b0, r_rdata[4:0]} + LEN_OVERHEAD) : 6'd0;
        w_rbyte   = i_cmd.rd_byte_done ? r_rdata : 8'd0;
        w_res     = {w_ignored, w_rbyte, w_mlen, w_open_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res <= w_res;
        end
        if (i_cmd.load_now) begin
            r_out_data <= w_res;
        end else if (i_cmd.load_held) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_now || i_cmd.load_held) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.func       = r_func;
    assign o_status.msg_open   = r_open;
    assign o_status.rd_empty   = w_rd_empty;
    assign o_status.drain_zero = (r_drain_left == 6'd0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/framed_message_ring_buffer_unit.sv
// Top level of the framed message ring buffer: controller plus datapath.
// A result is registered at the end of the execute state that follows its word's acceptance,
// or at the end of a further state for a close of an open message, a read start on a nonempty
// ring and a read byte with bytes left; only then does the controller return to idle for the next word.
// A result that cannot enter the busy output register holds the input off until it can.
// Synchronous active-low reset empties the ring; the byte store itself is not cleared.
module framed_message_ring_buffer_unit
    import fmrb_pkg::*;
#(
    parameter int STORE_DEPTH = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: data_byte[7:0], is_char[8], zero fill[15:9].
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: func[2:0].
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: open_ok[0], message_length[6:1], read_byte[14:7], ignored[15].
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;

    fmrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fmrb_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
